// ===== rtl/core/sidt_pkg.sv =====
// ----------------------------------------------------------------------------
// Session ID table package
// Request and response words, opcode and status codes, and the controller
// command word shared by the session ID table modules.
// ----------------------------------------------------------------------------
package sidt_pkg;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_LOOKUP  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_FREE   = 2'd1;
	localparam logic [1:0] ST_NOT_VALID = 2'd2;

	localparam int unsigned SID_W = 10;

	typedef struct packed {
		logic [1:0]       op;
		logic [SID_W-1:0] session_id;
		logic [31:0]      local_ip;
		logic [31:0]      remote_ip;
		logic [15:0]      local_port;
		logic [15:0]      remote_port;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [SID_W-1:0] result_id;
		logic [31:0]      tuple_local_ip;
		logic [31:0]      tuple_remote_ip;
		logic [15:0]      tuple_local_port;
		logic [15:0]      tuple_remote_port;
		logic [15:0]      used_count;
		logic [15:0]      released_count;
	} rsp_t;

	// Controller to datapath command word
	typedef struct packed {
		logic load;  // capture request word, launch memory reads
		logic exec;  // update tables and counters, load response register
	} ctl_cmd_t;

endpackage

// ===== rtl/core/sidt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Session ID table controller
// Two-state sequencer: accept a request, then run the update cycle.
// ----------------------------------------------------------------------------
module sidt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output sidt_pkg::ctl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q == ST_EXEC);
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.exec = (state_q == ST_EXEC);

endmodule

// ===== rtl/core/sidt_dp.sv =====
// ----------------------------------------------------------------------------
// Session ID table datapath
// Free-list FIFO, tuple and valid memories, pointers, counters and the
// registered response word.
// ----------------------------------------------------------------------------
module sidt_dp #(
	parameter int unsigned SESSIONS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sidt_pkg::ctl_cmd_t cmd,
	input  sidt_pkg::req_t     req,
	output logic               done,
	output sidt_pkg::rsp_t     rsp
);

	localparam int unsigned IDW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int unsigned CW  = $clog2(SESSIONS + 1);
	localparam int unsigned TW  = 96;

	// Memories: no reset, entries gated by first-lap watermarks
	logic [IDW-1:0] free_mem  [SESSIONS];
	logic [TW-1:0]  tuple_mem [SESSIONS];
	logic           valid_mem [SESSIONS];

	logic [IDW-1:0] head_q, tail_q;
	logic           head_wrap_q, tail_wrap_q;
	logic [CW-1:0]  free_count_q;
	logic [15:0]    used_q, rel_q;

	sidt_pkg::req_t req_s1;
	logic [IDW-1:0] free_rd_s1;
	logic [TW-1:0]  tuple_rd_s1;
	logic           valid_rd_s1;
	logic           head_fresh_s1;
	logic           touched_s1;
	logic           in_range_s1;

	sidt_pkg::rsp_t rsp_q;
	logic           done_q;

	logic [IDW-1:0] sid_addr;
	logic           sid_in_range;
	logic [IDW-1:0] sid_addr_s1;
	logic [IDW-1:0] id_pop;
	logic [IDW-1:0] head_nxt, tail_nxt;
	logic           do_pop, do_push, rel_ok;
	sidt_pkg::rsp_t rsp_d;
	logic [15:0]    used_d, rel_d;

	assign sid_addr     = IDW'(req.session_id);
	assign sid_in_range = (32'(req.session_id) < 32'(SESSIONS));
	assign sid_addr_s1  = IDW'(req_s1.session_id);

	assign head_nxt = (head_q == IDW'(SESSIONS - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == IDW'(SESSIONS - 1)) ? '0 : tail_q + 1'b1;

	// Slot never written since reset still holds its own position
	assign id_pop = head_fresh_s1 ? head_q : free_rd_s1;

	always_comb begin
		rsp_d   = '0;
		do_pop  = 1'b0;
		do_push = 1'b0;
		rel_ok  = 1'b0;
		used_d  = used_q;
		rel_d   = rel_q;
		case (req_s1.op)
			sidt_pkg::OP_ALLOC: begin
				if (free_count_q == '0) begin
					rsp_d.status = sidt_pkg::ST_NO_FREE;
				end else begin
					do_pop          = 1'b1;
					used_d          = used_q + 16'd1;
					rsp_d.result_id = sidt_pkg::SID_W'(id_pop);
				end
			end
			sidt_pkg::OP_RELEASE: begin
				rsp_d.result_id = req_s1.session_id;
				if (in_range_s1 && touched_s1 && valid_rd_s1) begin
					rel_ok                  = 1'b1;
					do_push                 = (free_count_q < CW'(SESSIONS));
					used_d                  = used_q - 16'd1;
					rel_d                   = rel_q + 16'd1;
					rsp_d.tuple_local_ip    = tuple_rd_s1[95:64];
					rsp_d.tuple_remote_ip   = tuple_rd_s1[63:32];
					rsp_d.tuple_local_port  = tuple_rd_s1[31:16];
					rsp_d.tuple_remote_port = tuple_rd_s1[15:0];
				end else begin
					rsp_d.status = sidt_pkg::ST_NOT_VALID;
				end
			end
			sidt_pkg::OP_LOOKUP: begin
				rsp_d.result_id = req_s1.session_id;
				if (in_range_s1) begin
					rsp_d.tuple_local_ip    = tuple_rd_s1[95:64];
					rsp_d.tuple_remote_ip   = tuple_rd_s1[63:32];
					rsp_d.tuple_local_port  = tuple_rd_s1[31:16];
					rsp_d.tuple_remote_port = tuple_rd_s1[15:0];
				end
			end
			default: begin
			end
		endcase
		rsp_d.used_count     = used_d;
		rsp_d.released_count = rel_d;
	end

	// Request capture and watermark flags
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1        <= req;
			head_fresh_s1 <= !(tail_wrap_q || (head_q < tail_q));
			touched_s1    <= head_wrap_q || (sid_addr < head_q);
			in_range_s1   <= sid_in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_push) begin
			free_mem[tail_q] <= sid_addr_s1;
		end
		if (cmd.load) begin
			free_rd_s1 <= free_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_pop) begin
			tuple_mem[id_pop] <= {req_s1.local_ip, req_s1.remote_ip,
				req_s1.local_port, req_s1.remote_port};
		end
		if (cmd.load) begin
			tuple_rd_s1 <= tuple_mem[sid_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (do_pop || rel_ok)) begin
			valid_mem[do_pop ? id_pop : sid_addr_s1] <= do_pop;
		end
		if (cmd.load) begin
			valid_rd_s1 <= valid_mem[sid_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			head_wrap_q  <= 1'b0;
			tail_wrap_q  <= 1'b0;
			free_count_q <= CW'(SESSIONS);
			used_q       <= '0;
			rel_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) begin
				used_q <= used_d;
				rel_q  <= rel_d;
				if (do_pop) begin
					head_q       <= head_nxt;
					free_count_q <= free_count_q - 1'b1;
					if (head_nxt == '0) begin
						head_wrap_q <= 1'b1;
					end
				end
				if (do_push) begin
					tail_q       <= tail_nxt;
					free_count_q <= free_count_q + 1'b1;
					if (tail_nxt == '0) begin
						tail_wrap_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/core/session_id_table_manager.sv =====
// ----------------------------------------------------------------------------
// Session ID table manager
// Allocates and recycles TCP session IDs through a FIFO free list and keeps
// the four-tuple of every live session in a reverse table.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request word on req and raise start; the word is taken at the
//   clock edge where start is high and busy is low. op selects allocate,
//   release or reverse lookup.
//   One response word per request appears on rsp, flagged by done, which is
//   high for exactly one cycle. The receiver cannot hold it off: capture it then.
// Pipeline and handshake:
//   The request word and the memory reads are registered at the accepting
//   edge; the update state then loads the response register that drives rsp.
//   busy is high for the one update cycle after accept, so the block takes no
//   new request until the update is done, but takes one while the previous
//   response is on display. The update state writes the results back to the
//   free-list, tuple and valid memories.
// Reset:
//   arst_n clears pointers, counters and control at once; all IDs start
//   free in ascending order. No clearing pass runs: entries never touched
//   since reset are recognized by head and tail first-lap watermarks, so the
//   block takes requests as soon as reset is released.
// ----------------------------------------------------------------------------
module session_id_table_manager #(
	parameter int unsigned SESSIONS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sidt_pkg::req_t req,
	output logic           done,
	output sidt_pkg::rsp_t rsp
);

	sidt_pkg::ctl_cmd_t cmd;

	// Sequence accept and update cycles
	sidt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Hold tables, pointers and counters; register the response word
	sidt_dp #(
		.SESSIONS (SESSIONS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ===== rtl/core/sidt_checker.sv =====
// ----------------------------------------------------------------------------
// Session ID table port checker
// Timing of accept, busy and done, and response consistency at the ports.
// ----------------------------------------------------------------------------
module sidt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input sidt_pkg::rsp_t rsp
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("update cycle not followed by a response");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response without an update cycle");

	a_no_free_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == sidt_pkg::ST_NO_FREE)) |->
		((rsp.result_id == '0) && (rsp.tuple_local_port == '0)))
		else $error("no-free response carries an ID or tuple");

endmodule

bind session_id_table_manager sidt_checker u_sidt_checker (.*);

// ===== tb/session_id_table_manager_tb.sv =====
// ----------------------------------------------------------------------------
// Session ID table manager testbench
// Sends allocate, release, reverse lookup and unused-opcode words through the
// start/busy handshake with random gaps. A predictor keeps its own free list,
// tuple table, valid bits and counters, and works out each response word. The
// response words are checked field by field against it, in order.
// ----------------------------------------------------------------------------
module session_id_table_manager_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SESSIONS    = 1024;
	localparam int unsigned MAX_GAP     = 12;
	localparam int unsigned RSP_LATENCY = 2;
	localparam int unsigned DRAIN_LIMIT = 1000;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	sidt_pkg::req_t req;
	sidt_pkg::rsp_t rsp;

	// Predictor state: mirror of the free list, the reverse table and the counters
	logic [sidt_pkg::SID_W-1:0] free_list [SESSIONS];
	int unsigned      free_head;
	int unsigned      free_tail;
	int unsigned      free_cnt;
	logic [63:0]      ip_table   [SESSIONS];
	logic [31:0]      port_table [SESSIONS];
	bit               live       [SESSIONS];
	bit               written    [SESSIONS];
	logic [15:0]      used_total;
	logic [15:0]      released_total;

	sidt_pkg::rsp_t expected_rsp [$];
	sidt_pkg::rsp_t oldest_rsp;
	int unsigned error_count;
	bit          back_to_back;

	session_id_table_manager #(
		.SESSIONS(SESSIONS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run
	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// All IDs free in ascending order, no live session, counters at zero.
	function automatic void reset_session_model();
		for (int unsigned i = 0; i < SESSIONS; i++) begin
			free_list[i] = sidt_pkg::SID_W'(i);
			live[i]      = 1'b0;
			written[i]   = 1'b0;
		end
		free_head      = 0;
		free_tail      = 0;
		free_cnt       = SESSIONS;
		used_total     = '0;
		released_total = '0;
	endfunction

	// Apply one accepted request word to the mirror and return the response
	// word the block must give for it.
	function automatic sidt_pkg::rsp_t predict_response(sidt_pkg::req_t w);
		sidt_pkg::rsp_t             r;
		logic [sidt_pkg::SID_W-1:0] id;
		r = '0;
		case (w.op)
			sidt_pkg::OP_ALLOC: begin
				if (free_cnt == 0) begin
					// Table full: report it, leave everything as it is
					r.status = sidt_pkg::ST_NO_FREE;
				end else begin
					id             = free_list[free_head];
					free_head      = (free_head + 1) % SESSIONS;
					free_cnt       = free_cnt - 1;
					ip_table[id]   = {w.local_ip, w.remote_ip};
					port_table[id] = {w.local_port, w.remote_port};
					live[id]       = 1'b1;
					written[id]    = 1'b1;
					used_total     = used_total + 16'd1;
					r.result_id    = id;
				end
			end
			sidt_pkg::OP_RELEASE: begin
				r.result_id = w.session_id;
				if (live[w.session_id]) begin
					{r.tuple_local_ip, r.tuple_remote_ip}     = ip_table[w.session_id];
					{r.tuple_local_port, r.tuple_remote_port} = port_table[w.session_id];
					live[w.session_id] = 1'b0;
					// Recycle the ID at the tail; a push into a full list is dropped
					if (free_cnt < SESSIONS) begin
						free_list[free_tail] = w.session_id;
						free_tail            = (free_tail + 1) % SESSIONS;
						free_cnt             = free_cnt + 1;
					end
					used_total     = used_total - 16'd1;
					released_total = released_total + 16'd1;
				end else begin
					r.status = sidt_pkg::ST_NOT_VALID;
				end
			end
			sidt_pkg::OP_LOOKUP: begin
				// No valid check: a released entry still shows its old tuple
				r.result_id = w.session_id;
				{r.tuple_local_ip, r.tuple_remote_ip}     = ip_table[w.session_id];
				{r.tuple_local_port, r.tuple_remote_port} = port_table[w.session_id];
			end
			default: begin
				// Unused opcode: all zero except the counters
			end
		endcase
		r.used_count     = used_total;
		r.released_count = released_total;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Response checker
	// ------------------------------------------------------------------------

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	// A response word is flagged by done for one cycle only: take it at the edge
	// that ends that cycle and hold it against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_rsp.size() == 0) begin
				$error("response word with none expected: result_id 0x%0h", rsp.result_id);
				error_count++;
			end else begin
				oldest_rsp = expected_rsp.pop_front();
				compare_field("status", 32'(oldest_rsp.status), 32'(rsp.status));
				compare_field("result_id", 32'(oldest_rsp.result_id),
					32'(rsp.result_id));
				compare_field("tuple_local_ip", oldest_rsp.tuple_local_ip,
					rsp.tuple_local_ip);
				compare_field("tuple_remote_ip", oldest_rsp.tuple_remote_ip,
					rsp.tuple_remote_ip);
				compare_field("tuple_local_port", 32'(oldest_rsp.tuple_local_port),
					32'(rsp.tuple_local_port));
				compare_field("tuple_remote_port", 32'(oldest_rsp.tuple_remote_port),
					32'(rsp.tuple_remote_port));
				compare_field("used_count", 32'(oldest_rsp.used_count),
					32'(rsp.used_count));
				compare_field("released_count", 32'(oldest_rsp.released_count),
					32'(rsp.released_count));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Send one request word: idle for a random gap (none in a burst),
	// then hold start until an edge sees busy low, and predict at that edge.
	// start stays high on return so a back-to-back word follows without a bubble.
	task automatic send_word(sidt_pkg::req_t w);
		int unsigned gap;
		gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req   <= w;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsp.push_back(predict_response(w));
	endtask

	// Drop start and hold off until every predicted word has come back.
	task automatic wait_for_responses();
		int unsigned cycles;
		start <= 1'b0;
		cycles = 0;
		while (expected_rsp.size() != 0 && cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
	endtask

	function automatic sidt_pkg::req_t make_word(logic [1:0] op,
		logic [sidt_pkg::SID_W-1:0] sid, logic [31:0] lip, logic [31:0] rip,
		logic [15:0] lport, logic [15:0] rport);
		sidt_pkg::req_t w;
		w.op          = op;
		w.session_id  = sid;
		w.local_ip    = lip;
		w.remote_ip   = rip;
		w.local_port  = lport;
		w.remote_port = rport;
		return w;
	endfunction

	function automatic sidt_pkg::req_t random_word(logic [1:0] op);
		return make_word(op, sidt_pkg::SID_W'($urandom_range(0, SESSIONS - 1)),
			$urandom, $urandom, 16'($urandom), 16'($urandom));
	endfunction

	// Find an ID that is live (or, for lookups, has ever held a tuple),
	// scanning from a random point. Lookups never touch unwritten entries.
	function automatic logic [sidt_pkg::SID_W-1:0] pick_id(bit need_live);
		int unsigned                origin;
		logic [sidt_pkg::SID_W-1:0] id;
		origin = $urandom_range(0, SESSIONS - 1);
		for (int unsigned i = 0; i < SESSIONS; i++) begin
			id = sidt_pkg::SID_W'((origin + i) % SESSIONS);
			if (need_live ? live[id] : written[id])
				return id;
		end
		return sidt_pkg::SID_W'(origin);
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Extremes of the tuple fields, every opcode, release of a dead ID before
	// and after use, lookup of a released entry, and the unused opcode.
	task automatic test_directed();
		back_to_back = 1'b0;
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'h3FF, '0, '0, '0, '0));
		send_word(make_word(OP_UNUSED, '0, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_ALLOC, '0, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_ALLOC, 10'h3FF, '1, '1, '1, '1));
		send_word(make_word(sidt_pkg::OP_LOOKUP, 10'd0, '1, '1, '1, '1));
		send_word(make_word(sidt_pkg::OP_LOOKUP, 10'd1, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'd0, '1, '1, '1, '1));
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'd0, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_LOOKUP, 10'd0, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_ALLOC, 10'h155, 32'hAAAA_5555, 32'h5555_AAAA,
			16'hA5A5, 16'h5A5A));
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'd1, '0, '0, '0, '0));
		send_word(make_word(OP_UNUSED, 10'h3FF, '1, '1, '1, '1));
		back_to_back = 1'b1;
		send_word(make_word(sidt_pkg::OP_ALLOC, 10'h2AA, 32'h0000_0001, 32'h8000_0000,
			16'h0001, 16'h8000));
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'd3, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'd2, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_LOOKUP, 10'd3, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_LOOKUP, 10'd2, '0, '0, '0, '0));
		send_word(make_word(sidt_pkg::OP_RELEASE, 10'd3, '0, '0, '0, '0));
	endtask

	// Mixed traffic: mostly allocate and release of live sessions, some
	// releases of arbitrary IDs, lookups of written entries and unused opcodes.
	// Bursts without gaps come and go every few dozen words.
	task automatic test_random_mix(int unsigned count);
		int unsigned    roll;
		sidt_pkg::req_t w;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 48 == 0)
				back_to_back = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				w = random_word(sidt_pkg::OP_ALLOC);
			end else if (roll < 70) begin
				w = random_word(sidt_pkg::OP_RELEASE);
				if (free_cnt < SESSIONS)
					w.session_id = pick_id(1'b1);
			end else if (roll < 80) begin
				w = random_word(sidt_pkg::OP_RELEASE);
			end else if (roll < 95) begin
				w = random_word(sidt_pkg::OP_LOOKUP);
				w.session_id = pick_id(1'b0);
			end else begin
				w = random_word(OP_UNUSED);
			end
			send_word(w);
		end
	endtask

	// Allocate until no ID is left, partly in bursts, then ask a few more
	// times on the empty list; drain fully before moving on.
	task automatic test_fill_table();
		int unsigned n;
		n = 0;
		while (free_cnt != 0) begin
			if (n % 100 == 0)
				back_to_back = ($urandom_range(0, 1) == 0);
			send_word(random_word(sidt_pkg::OP_ALLOC));
			n++;
		end
		back_to_back = 1'b0;
		repeat (4) send_word(random_word(sidt_pkg::OP_ALLOC));
		wait_for_responses();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		error_count  = 0;
		back_to_back = 1'b0;
		reset_session_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix(300);
		test_fill_table();
		test_random_mix(280);

		// Let the last words come back, then allow the pipeline to settle
		wait_for_responses();
		repeat (RSP_LATENCY + 4) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$error("%0d response words never arrived", expected_rsp.size());
			error_count++;
		end

		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sidt_pkg.sv
rtl/core/sidt_ctrl.sv
rtl/core/sidt_dp.sv
rtl/core/session_id_table_manager.sv
rtl/core/sidt_checker.sv
tb/session_id_table_manager_tb.sv
